@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL of the filter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RADF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define RADF_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/radf_pkg.sv @@
// ----------------------------------------------------------------------------
// radf_pkg
// Types and constants shared by the recent address filter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package radf_pkg;

   localparam int ADDR_W     = 48;
   localparam int TIME_W     = 32;
   localparam int EXPIRY_W   = 16;
   localparam int SLOT_OUT_W = 4;

   localparam int                  DEFAULT_SLOTS = 16;
   localparam logic [EXPIRY_W-1:0] EXPIRY_RESET  = 16'd5000;

   typedef struct packed {
      logic [ADDR_W-1:0] device_address;
      logic [TIME_W-1:0] now_ms;
   } req_word_type;

   typedef struct packed {
      logic                  is_new;
      logic                  was_refreshed;
      logic                  table_full;
      logic [SLOT_OUT_W-1:0] slot_index;
   } rsp_word_type;

   // Lookup probe walking the cell chain.
   typedef struct packed {
      logic              valid;
      logic              found;
      logic              free_found;
      logic [ADDR_W-1:0] device_address;
      logic [TIME_W-1:0] now_ms;
   } probe_type;

   // Insertion broadcast to every cell.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] device_address;
      logic [TIME_W-1:0] now_ms;
   } commit_type;

endpackage

`default_nettype wire

@@ rtl/radf_cell.sv @@
// ----------------------------------------------------------------------------
// radf_cell
// One table slot: holds an address entry and checks the passing probe.
// ----------------------------------------------------------------------------
`default_nettype none

module radf_cell #(
   parameter int IDX_W      = 4,
   parameter int CELL_INDEX = 0
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [radf_pkg::EXPIRY_W-1:0]    expiry_ms,
   input  wire radf_pkg::probe_type              probe_in,
   input  wire logic [IDX_W-1:0]                 idx_in,
   output      radf_pkg::probe_type              probe_out,
   output      logic [IDX_W-1:0]                 idx_out,
   input  wire radf_pkg::commit_type             commit,
   input  wire logic [IDX_W-1:0]                 commit_idx
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

   logic                          valid_ff, valid_in;
   logic [radf_pkg::ADDR_W-1:0]   addr_ff, addr_in;
   logic [radf_pkg::TIME_W-1:0]   seen_ff, seen_in;
   radf_pkg::probe_type           probe_ff, probe_in_next;
   logic                          probe_valid_ff;
   logic [IDX_W-1:0]              idx_ff, idx_in_next;

   logic [radf_pkg::TIME_W-1:0]   age;
   logic                          live;
   logic                          hit;

   assign age  = probe_in.now_ms - seen_ff;
   assign live = valid_ff &&
                 (age <= {{(radf_pkg::TIME_W-radf_pkg::EXPIRY_W){1'b0}}, expiry_ms});
   assign hit  = probe_in.valid && !probe_in.found && live &&
                 (addr_ff == probe_in.device_address);

   always_comb begin
      probe_in_next = probe_in;
      idx_in_next   = idx_in;
      if (hit) begin
         probe_in_next.found = 1'b1;
         idx_in_next         = MY_IDX;
      end else if (probe_in.valid && !probe_in.found && !live && !probe_in.free_found) begin
         probe_in_next.free_found = 1'b1;
         idx_in_next              = MY_IDX;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      addr_in  = addr_ff;
      seen_in  = seen_ff;
      if (hit) begin
         seen_in = probe_in.now_ms;
      end else if (commit.en && (commit_idx == MY_IDX)) begin
         valid_in = 1'b1;
         addr_in  = commit.device_address;
         seen_in  = commit.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         probe_valid_ff <= 1'b0;
      end else begin
         valid_ff       <= valid_in;
         probe_valid_ff <= probe_in_next.valid;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      seen_ff  <= seen_in;
      probe_ff <= probe_in_next;
      idx_ff   <= idx_in_next;
   end

   // The valid flag comes from its own reset register.
   always_comb begin
      probe_out       = probe_ff;
      probe_out.valid = probe_valid_ff;
   end

   assign idx_out = idx_ff;

endmodule

`default_nettype wire

@@ rtl/recent_address_dedup_filter.sv @@
// ----------------------------------------------------------------------------
// recent_address_dedup_filter
// Duplicate filter for advertising reports with aging of stored addresses.
// ----------------------------------------------------------------------------
// Each accepted word carries a device address and the current millisecond
// time, and yields exactly one response word: refreshed when a live entry
// holds the same address, new when the address was stored in the lowest free
// slot, or table full when nothing was free. An entry is live while its age,
// taken modulo 2^32, is at most csr expiry. The table is a row of SLOTS cells;
// a lookup probe walks the row one cell per cycle, and the outcome at the end
// of the row is registered into the output. The next word is taken only once
// the probe has left the row, so one word at a time is in the table. A finished
// response may wait in the output register and a second one in a holding
// stage, so a new word is accepted while the output is stalled, until the
// holding stage is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module recent_address_dedup_filter #(
   parameter int SLOTS = radf_pkg::DEFAULT_SLOTS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_ready,
   input  wire radf_pkg::req_word_type          req_word,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   output      radf_pkg::rsp_word_type          rsp_word,
   input  wire logic                            csr_wr_en,
   input  wire logic [radf_pkg::EXPIRY_W-1:0]   csr_wr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   // Expiry register, to be written only while the block is idle; the block does not enforce this.
   logic [radf_pkg::EXPIRY_W-1:0] expiry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= radf_pkg::EXPIRY_RESET;
      end else if (csr_wr_en) begin
         expiry_ff <= csr_wr_data;
      end
   end

   // Probe chain: element 0 is the injected word, element SLOTS the tail.
   radf_pkg::probe_type probe [SLOTS+1];
   logic [IDX_W-1:0]    pidx  [SLOTS+1];
   logic [SLOTS:0]      chain_valid;
   radf_pkg::commit_type commit;
   logic [IDX_W-1:0]    commit_idx;
   logic                req_accept;

   assign req_accept = req_valid && req_ready;

   // Fields in order: valid, found, free_found, address, time.
   assign probe[0] = {req_accept, 1'b0, 1'b0, req_word.device_address, req_word.now_ms};
   assign pidx[0]  = '0;

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      radf_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .expiry_ms  (expiry_ff),
         .probe_in   (probe[i]),
         .idx_in     (pidx[i]),
         .probe_out  (probe[i+1]),
         .idx_out    (pidx[i+1]),
         .commit     (commit),
         .commit_idx (commit_idx)
      );
   end

   for (genvar i = 0; i <= SLOTS; i++) begin : g_valid
      assign chain_valid[i] = probe[i].valid;
   end

   // The tail decides the outcome; a miss with a free slot is written back
   // into that slot through the commit broadcast in the same cycle.
   logic                   tail_valid;
   radf_pkg::rsp_word_type tail_word;
   logic [IDX_W+3:0]       tail_idx_wide;

   assign tail_valid    = probe[SLOTS].valid;
   assign tail_idx_wide = {4'b0, pidx[SLOTS]};

   always_comb begin
      tail_word               = '0;
      commit.en               = 1'b0;
      commit.device_address   = probe[SLOTS].device_address;
      commit.now_ms           = probe[SLOTS].now_ms;
      commit_idx              = pidx[SLOTS];
      if (probe[SLOTS].found) begin
         tail_word.was_refreshed = 1'b1;
         tail_word.slot_index    = tail_idx_wide[3:0];
      end else if (probe[SLOTS].free_found) begin
         tail_word.is_new        = 1'b1;
         tail_word.slot_index    = tail_idx_wide[3:0];
         commit.en               = tail_valid;
      end else begin
         tail_word.table_full    = 1'b1;
      end
   end

   // Output register plus one holding stage.
   logic                   busy_ff, busy_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   radf_pkg::rsp_word_type rsp_word_ff, rsp_word_in;
   logic                   hold_valid_ff, hold_valid_in;
   radf_pkg::rsp_word_type hold_word_ff, hold_word_in;
   logic                   rsp_take;

   assign rsp_take  = rsp_valid_ff && rsp_ready;
   assign req_ready = !busy_ff && !hold_valid_ff;

   always_comb begin
      busy_in = busy_ff;
      if (req_accept) begin
         busy_in = 1'b1;
      end else if (tail_valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_word_in   = rsp_word_ff;
      hold_valid_in = hold_valid_ff;
      hold_word_in  = hold_word_ff;
      if (rsp_take) begin
         rsp_valid_in  = hold_valid_ff;
         rsp_word_in   = hold_word_ff;
         hold_valid_in = 1'b0;
      end
      if (tail_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_word_in  = tail_word;
         end else begin
            hold_valid_in = 1'b1;
            hold_word_in  = tail_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff  <= rsp_word_in;
      hold_word_ff <= hold_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Only one probe may be in the chain at any time.
   `RADF_ASSERT(a_one_probe, clock, reset, $onehot0(chain_valid))
   // The busy flag tracks exactly the probe held in the chain registers.
   `RADF_ASSERT(a_busy_tracks_chain, clock, reset, busy_ff == (|chain_valid[SLOTS:1]))
   // The holding stage is only used behind an occupied output register.
   `RADF_ASSERT_IMPL(a_hold_behind_rsp, clock, reset, hold_valid_ff, rsp_valid_ff)
   // Every response reports exactly one outcome.
   `RADF_ASSERT_IMPL(a_one_outcome, clock, reset, rsp_valid_ff, $onehot({rsp_word_ff.is_new, rsp_word_ff.was_refreshed, rsp_word_ff.table_full}))

endmodule

`default_nettype wire
